// ===== design/bta_pkg.sv =====
// Shared types and constants for the bakery ticket arbiter.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package bta_pkg;

  localparam int OP_W         = 1;
  localparam int ID_W         = 4;
  localparam int OUT_TICKET_W = 16;

  // Operation codes carried in the operation field.
  localparam logic [OP_W-1:0] OP_TAKE    = 1'b0;
  localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

  // Status codes reported with every result.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] requester_id;
  } bta_in_t;

  typedef struct packed {
    logic [OUT_TICKET_W-1:0] assigned_ticket;
    logic                    grant_valid;
    logic [ID_W-1:0]         grant_id;
    logic                    status;
  } bta_out_t;

endpackage

// ===== design/bta_tree.sv =====
// Comparison tree over all held tickets: largest ticket and lowest nonzero ticket.
// Depends on nothing but its parameters; instantiated by the arbiter top level.
`timescale 1ns / 1ps

module bta_tree #(
  parameter int N = 12,
  parameter int W = 16
) (
  input  logic [W-1:0]         tickets [N],
  output logic [W-1:0]         max_ticket,
  output logic                 min_valid,
  output logic [$clog2(N)-1:0] min_idx
);

  localparam int IDXW = $clog2(N);
  localparam int P    = 1 << IDXW;

  // Heap layout: leaves sit at P..2P-1, node k combines nodes 2k and 2k+1.
  logic [W-1:0]    mx [2*P];
  logic            mv [2*P];
  logic [W-1:0]    mt [2*P];
  logic [IDXW-1:0] mi [2*P];

  always_comb begin
    for (int i = 0; i < 2 * P; i++) begin
      mx[i] = '0;
      mv[i] = 1'b0;
      mt[i] = '0;
      mi[i] = '0;
    end
    for (int i = 0; i < P; i++) begin
      if (i < N) begin
        mx[P+i] = tickets[i];
        mv[P+i] = (tickets[i] != '0);
        mt[P+i] = tickets[i];
        mi[P+i] = IDXW'(i);
      end
    end
    for (int k = P - 1; k >= 1; k--) begin
      mx[k] = (mx[2*k] >= mx[2*k+1]) ? mx[2*k] : mx[2*k+1];
      // The left child covers lower indices, so it wins a tie.
      if (mv[2*k] && (!mv[2*k+1] || (mt[2*k] <= mt[2*k+1]))) begin
        mv[k] = mv[2*k];
        mt[k] = mt[2*k];
        mi[k] = mi[2*k];
      end else begin
        mv[k] = mv[2*k+1];
        mt[k] = mt[2*k+1];
        mi[k] = mi[2*k+1];
      end
    end
  end

  assign max_ticket = mx[1];
  assign min_valid  = mv[1];
  assign min_idx    = mv[1] ? mi[1] : '0;

endmodule

// ===== design/bakery_ticket_arbiter_top.sv =====
// Top level of the bakery ticket arbiter: input register, ticket store, result stages.
// Depends on bta_pkg and bta_tree.
`timescale 1ns / 1ps

// Channel   Ports                     Direction  Transfer
// input     start, busy, in_item      in         edge with start high and busy low
// result    out_strobe, out_result    out        every edge that ends a strobe cycle
//
// The block takes one item in every cycle; busy is never raised.
// A result passes the input register, then the store update with the middle stage,
// whose ticket comes from the largest-ticket tree, then the result stage, whose
// grant is taken from the updated store through the lowest-ticket tree.
// Reset is synchronous and active low; it clears the ticket store and the valid flag of every stage.
// The receiver cannot stall, so no result is ever held back.

module bakery_ticket_arbiter_top #(
  parameter int REQUESTERS  = 12,
  parameter int TICKET_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bta_pkg::bta_in_t  in_item,
  output logic              out_strobe,
  output bta_pkg::bta_out_t out_result
);

  import bta_pkg::*;

  localparam int IDXW = $clog2(REQUESTERS);

  // Input register stage.
  logic    in_valid_r, in_valid_nxt;
  bta_in_t in_r, in_nxt;

  // Ticket store; every entry is read at its own place by the tree.
  logic [TICKET_BITS-1:0] store_r [REQUESTERS];

  // Middle stage: ticket and status of the item just applied to the store.
  logic                    a_valid_r, a_valid_nxt;
  logic [OUT_TICKET_W-1:0] a_ticket_r, a_ticket_nxt;
  logic                    a_status_r, a_status_nxt;

  // Result stage.
  logic     out_strobe_r, out_strobe_nxt;
  bta_out_t out_r, out_nxt;

  logic [TICKET_BITS-1:0] max_ticket;
  logic                   min_valid;
  logic [IDXW-1:0]        min_idx;

  logic                   id_ok;
  logic                   overflow;
  logic [TICKET_BITS-1:0] next_ticket;
  logic                   wr_en;
  logic [IDXW-1:0]        wr_idx;
  logic [TICKET_BITS-1:0] wr_data;

  bta_tree #(
    .N (REQUESTERS),
    .W (TICKET_BITS)
  ) u_tree (
    .tickets    (store_r),
    .max_ticket (max_ticket),
    .min_valid  (min_valid),
    .min_idx    (min_idx)
  );

  assign busy = 1'b0;

  // Input register capture.
  always_comb begin
    in_valid_nxt = start && !busy;
    in_nxt       = in_item;
  end

  // Store update for the item held in the input register. The largest ticket
  // is read from the store as it stands, which already includes every earlier item.
  always_comb begin
    id_ok       = (32'(in_r.requester_id) < 32'(REQUESTERS));
    overflow    = (max_ticket == '1);
    next_ticket = max_ticket + TICKET_BITS'(1);
    wr_idx      = IDXW'(in_r.requester_id);
    wr_en       = 1'b0;
    wr_data     = '0;
    a_ticket_nxt = '0;
    a_status_nxt = STATUS_OK;
    if (in_valid_r && id_ok) begin
      if (in_r.operation == OP_TAKE) begin
        if (overflow) begin
          a_status_nxt = STATUS_OVERFLOW;
        end else begin
          wr_en        = 1'b1;
          wr_data      = next_ticket;
          a_ticket_nxt = OUT_TICKET_W'(next_ticket);
        end
      end else begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
    end
    a_valid_nxt = in_valid_r;
  end

  // Result assembly: the grant reflects the store after this item's update.
  always_comb begin
    out_strobe_nxt             = a_valid_r;
    out_nxt.assigned_ticket    = a_ticket_r;
    out_nxt.status             = a_status_r;
    out_nxt.grant_valid        = min_valid;
    out_nxt.grant_id           = ID_W'(min_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      a_valid_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < REQUESTERS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      in_valid_r   <= in_valid_nxt;
      a_valid_r    <= a_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (wr_en) begin
        store_r[wr_idx] <= wr_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    a_ticket_r <= a_ticket_nxt;
    a_status_r <= a_status_nxt;
    out_r      <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

endmodule

// ===== design/bta_checker.sv =====
// Port-level checks for the bakery ticket arbiter and the bind that attaches them.
// Depends on bta_pkg and bakery_ticket_arbiter_top.
`timescale 1ns / 1ps

module bta_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input bta_pkg::bta_in_t  in_item,
  input logic              out_strobe,
  input bta_pkg::bta_out_t out_result
);

  import bta_pkg::*;

  // Every taken item yields its result.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("taken item produced no result");

  // No result appears without an item taken earlier.
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, 3))
    else $error("result without a taken item");

  // A refused take never reports a ticket.
  a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.status == STATUS_OVERFLOW) |-> (out_result.assigned_ticket == '0))
    else $error("overflow reported with a ticket");

  // A freshly assigned ticket means someone holds a ticket, so a grant exists.
  a_ticket_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.assigned_ticket != '0) |-> out_result.grant_valid)
    else $error("ticket assigned but no grant");

  // With no ticket held the grant index reads zero.
  a_idle_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result.grant_valid) |-> (out_result.grant_id == '0))
    else $error("grant index set without a grant");

endmodule

bind bakery_ticket_arbiter_top bta_checker u_bta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_result (out_result)
);

// ===== bench/tb_bakery_ticket_arbiter_top.sv =====
// Self-checking testbench for bakery_ticket_arbiter_top: a directed table followed by
// random traffic in several idle phases. Depends on bta_pkg and the design files.
`timescale 1ns / 1ps

module tb_bakery_ticket_arbiter_top;
  import bta_pkg::*;

  localparam int REQUESTERS  = 12;
  localparam int TICKET_BITS = 16;
  localparam logic [TICKET_BITS-1:0] TICKET_CEIL = '1;

  // Cycles without any transfer on either channel before the run is declared hung.
  // The longest legal gap is a run of sender idle cycles at 84 in a hundred, which
  // stays far below this figure.
  localparam int STALL_LIMIT = 2000;

  // Idle odds, in percent, for the phases of the random part.
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_HEAVY = 84;
  localparam int IDLE_LIGHT = 11;

  localparam int RANDOM_PER_PHASE = 425;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  bta_in_t  in_item;
  logic     out_strobe;
  bta_out_t out_result;

  bakery_ticket_arbiter_top #(
    .REQUESTERS (REQUESTERS),
    .TICKET_BITS(TICKET_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One row of stimulus. When pinned is set, golden holds the result typed in by hand
  // and is compared instead of the predictor's answer; the predictor still runs so
  // that its copy of the ticket store follows the block.
  typedef struct {
    bta_in_t  item;
    bit       pinned;
    bta_out_t golden;
  } plan_row_t;

  plan_row_t plan[$];
  plan_row_t issued_q[$];
  bta_out_t  expected_q[$];

  logic [TICKET_BITS-1:0] ticket_held[REQUESTERS];

  int error_count;
  int stall_cycles;

  // Largest ticket currently held by any requester, zero when none is held.
  function automatic logic [TICKET_BITS-1:0] largest_held();
    logic [TICKET_BITS-1:0] top;
    top = '0;
    for (int i = 0; i < REQUESTERS; i++) begin
      if (ticket_held[i] > top) top = ticket_held[i];
    end
    return top;
  endfunction

  // Applies one operation to the ticket store and returns the result it produces:
  // the ticket now held by the requester, the grant after the update and the status.
  function automatic bta_out_t predict_ticket(bta_in_t it);
    bta_out_t               res;
    logic [TICKET_BITS-1:0] top;
    logic [TICKET_BITS-1:0] best;
    res = '0;
    res.status = STATUS_OK;
    if (it.requester_id < REQUESTERS) begin
      if (it.operation == OP_TAKE) begin
        top = largest_held();
        if (top == TICKET_CEIL) begin
          // The ceiling is held already: the take is refused and nothing moves.
          res.status = STATUS_OVERFLOW;
        end else begin
          ticket_held[it.requester_id] = top + 1'b1;
          res.assigned_ticket = OUT_TICKET_W'(top + 1'b1);
        end
      end else begin
        ticket_held[it.requester_id] = '0;
      end
    end
    // Lowest nonzero ticket wins; a strict compare keeps the lower index on a tie.
    best = '0;
    for (int i = 0; i < REQUESTERS; i++) begin
      if (ticket_held[i] != '0 && (!res.grant_valid || ticket_held[i] < best)) begin
        best = ticket_held[i];
        res.grant_valid = 1'b1;
        res.grant_id = ID_W'(i);
      end
    end
    return res;
  endfunction

  // Appends one row to the directed table.
  task automatic add_row(input logic [OP_W-1:0] op, input int id, input bit pinned,
                         input int ticket = 0, input bit gnt_valid = 0,
                         input int gnt_id = 0, input logic st = STATUS_OK);
    plan_row_t row;
    row.item.operation = op;
    row.item.requester_id = ID_W'(id);
    row.pinned = pinned;
    row.golden.assigned_ticket = OUT_TICKET_W'(ticket);
    row.golden.grant_valid = gnt_valid;
    row.golden.grant_id = ID_W'(gnt_id);
    row.golden.status = st;
    plan.push_back(row);
  endtask

  // Offers one item, idling first with the given odds, and returns at the edge that
  // takes it. Each call drives start once per edge: either low for an idle cycle or
  // high with the new item, so start never toggles within one time step.
  task automatic send_item(input bta_in_t it, input bit pinned, input bta_out_t golden,
                           input int idle_pct);
    plan_row_t row;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    row.item = it;
    row.pinned = pinned;
    row.golden = golden;
    issued_q.push_back(row);
    start <= 1'b1;
    in_item <= it;
    // Sampled right at the edge, busy still holds its value from the cycle that ends.
    do @(posedge clk); while (busy);
  endtask

  // Random item: mostly takes and releases of requesters in range, with a share of
  // out-of-range indexes so that every bit of the index is exercised.
  function automatic bta_in_t random_item(int take_pct);
    bta_in_t it;
    it.operation = ($urandom_range(99) < take_pct) ? OP_TAKE : OP_RELEASE;
    if ($urandom_range(9) == 0) it.requester_id = ID_W'($urandom_range(15, REQUESTERS));
    else it.requester_id = ID_W'($urandom_range(REQUESTERS - 1));
    return it;
  endfunction

  // Waits until every transfer taken so far has come back as a result. Start drops
  // first so that the last item is not offered again. The first edge lets the monitor
  // record an item taken at the edge the caller returned from.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Monitor: at each edge, an input transfer enters the predictor and queues its
  // expectation; a result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    plan_row_t row;
    bta_out_t  predicted;
    bta_out_t  want;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (start && !busy) begin
        predicted = predict_ticket(in_item);
        if (issued_q.size() != 0) begin
          row = issued_q.pop_front();
          expected_q.push_back(row.pinned ? row.golden : predicted);
        end else begin
          $error("input transfer with no item issued by the driver");
          error_count++;
          expected_q.push_back(predicted);
        end
      end
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_result.assigned_ticket !== want.assigned_ticket) begin
            $error("assigned_ticket: expected %0d, actual %0d",
                   want.assigned_ticket, out_result.assigned_ticket);
            error_count++;
          end
          if (out_result.grant_valid !== want.grant_valid) begin
            $error("grant_valid: expected %0d, actual %0d",
                   want.grant_valid, out_result.grant_valid);
            error_count++;
          end
          if (out_result.grant_id !== want.grant_id) begin
            $error("grant_id: expected %0d, actual %0d", want.grant_id, out_result.grant_id);
            error_count++;
          end
          if (out_result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_result.status);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer has happened for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    bta_out_t none;

    none = '0;
    error_count = 0;
    stall_cycles = 0;
    for (int i = 0; i < REQUESTERS; i++) ticket_held[i] = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;

    // Reset is held low for a while and released once.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Rows with a typed result are the ones that can be read off at
    // a glance: the empty store after reset, the first tickets, out-of-range indexes,
    // a release without a ticket and the store emptied again.
    add_row(OP_RELEASE, 0,  1, 0, 0, 0);   // empty store right after reset
    add_row(OP_TAKE,    11, 1, 1, 1, 11);  // first ticket, highest index
    add_row(OP_TAKE,    0,  1, 2, 1, 11);  // lowest index, later ticket
    add_row(OP_TAKE,    15, 1, 0, 1, 11);  // index out of range, all bits set
    add_row(OP_RELEASE, 12, 1, 0, 1, 11);  // first index out of range
    add_row(OP_TAKE,    11, 1, 3, 1, 0);   // take while holding a ticket
    add_row(OP_RELEASE, 5,  1, 0, 1, 0);   // release without a ticket
    add_row(OP_TAKE,    5,  1, 4, 1, 0);
    add_row(OP_RELEASE, 0,  1, 0, 1, 11);
    add_row(OP_TAKE,    7,  0);
    add_row(OP_RELEASE, 11, 0);
    add_row(OP_TAKE,    14, 0);
    add_row(OP_RELEASE, 13, 0);
    add_row(OP_TAKE,    2,  0);
    add_row(OP_TAKE,    9,  0);
    add_row(OP_RELEASE, 9,  0);
    add_row(OP_RELEASE, 5,  0);
    add_row(OP_RELEASE, 7,  0);
    add_row(OP_RELEASE, 2,  1, 0, 0, 0);   // store empty again
    add_row(OP_TAKE,    10, 1, 1, 1, 10);
    add_row(OP_TAKE,    10, 1, 2, 1, 10);
    add_row(OP_RELEASE, 10, 1, 0, 0, 0);
    foreach (plan[i]) send_item(plan[i].item, plan[i].pinned, plan[i].golden, IDLE_NONE);

    // Random traffic in four phases: back to back, sparse, lightly idle, back to back.
    // Takes slightly outnumber releases so that several tickets are usually held.
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_item(random_item(55), 1'b0, none,
                  (phase == 1) ? IDLE_HEAVY : (phase == 2) ? IDLE_LIGHT : IDLE_NONE);
      end
    end

    // Let every result come back, then a few more edges to catch any stray strobe.
    drain();
    repeat (8) @(posedge clk);
    start <= 1'b0;
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
